// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define Q2E_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define Q2E_ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");
`else
`define Q2E_ASSERT(lbl, clk, rst_n, prop)
`define Q2E_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

// ----- src/q2e_pkg.sv -----
// ----------------------------------------------------------------------------
// q2e_pkg
// Types, constants and the arctangent table of the quaternion to Euler core.
// ----------------------------------------------------------------------------
package q2e_pkg;

    localparam int QUAT_WIDTH_DEF    = 16;
    localparam int ANGLE_WIDTH_DEF   = 16;
    localparam int CORDIC_STAGES_DEF = 16;

    localparam int PW   = 33;   // Q2.30 product
    localparam int DW   = 36;   // CORDIC x/y datapath
    localparam int ZW   = 34;   // CORDIC angle, pi = 2^31
    localparam int RW   = 62;   // square root remainder
    localparam int RTW  = 31;   // square root result
    localparam int SQ_STEPS = RTW;
    localparam int GPW  = 32;   // gimbal pitch, widest angle
    localparam int CFG_IW = 1;
    localparam int CFG_DW = 31;

    localparam logic [CFG_IW-1:0] REG_DIRECTION = 1'b0;
    localparam logic [CFG_IW-1:0] REG_THRESHOLD = 1'b1;

    localparam logic [CFG_DW-1:0] THRESHOLD_RESET = 31'd1073731087;

    localparam logic signed [DW-1:0] HALF_Q30 = DW'(64'sd536870912);
    localparam logic signed [ZW-1:0] PI_Z     = ZW'(64'sd2147483648);

    typedef struct packed {
        logic signed [DW-1:0] x;
        logic signed [DW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 zero;
    } lane_t;

    typedef struct packed {
        logic [RW-1:0]         rem;
        logic [RTW-1:0]        root;
        logic signed [31:0]    s;
        lane_t                 head;
        lane_t                 bank;
        logic                  lock;
        logic signed [GPW-1:0] gpitch;
    } sqrt_t;

    typedef struct packed {
        lane_t                 head;
        lane_t                 pitch;
        lane_t                 bank;
        logic                  lock;
        logic signed [GPW-1:0] gpitch;
    } cordic_t;

    function automatic logic signed [ZW-1:0] atan_angle(input logic [4:0] i);
        logic signed [ZW-1:0] a;
        unique case (i)
            5'd0:  a = ZW'(64'sd536870912);
            5'd1:  a = ZW'(64'sd316933406);
            5'd2:  a = ZW'(64'sd167458907);
            5'd3:  a = ZW'(64'sd85004756);
            5'd4:  a = ZW'(64'sd42667331);
            5'd5:  a = ZW'(64'sd21354465);
            5'd6:  a = ZW'(64'sd10679838);
            5'd7:  a = ZW'(64'sd5340245);
            5'd8:  a = ZW'(64'sd2670163);
            5'd9:  a = ZW'(64'sd1335087);
            5'd10: a = ZW'(64'sd667544);
            5'd11: a = ZW'(64'sd333772);
            5'd12: a = ZW'(64'sd166886);
            5'd13: a = ZW'(64'sd83443);
            5'd14: a = ZW'(64'sd41722);
            5'd15: a = ZW'(64'sd20861);
            5'd16: a = ZW'(64'sd10430);
            5'd17: a = ZW'(64'sd5215);
            5'd18: a = ZW'(64'sd2608);
            5'd19: a = ZW'(64'sd1304);
            5'd20: a = ZW'(64'sd652);
            5'd21: a = ZW'(64'sd326);
            5'd22: a = ZW'(64'sd163);
            5'd23: a = ZW'(64'sd81);
            5'd24: a = ZW'(64'sd41);
            5'd25: a = ZW'(64'sd20);
            5'd26: a = ZW'(64'sd10);
            5'd27: a = ZW'(64'sd5);
            5'd28: a = ZW'(64'sd3);
            5'd29: a = ZW'(64'sd1);
            5'd30: a = ZW'(64'sd1);
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

// ----- src/quaternion_to_euler_angles_core.sv -----
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles_core
// Unit quaternion to heading, pitch and bank binary angles with gimbal flag.
// Stages: 3 front, 31 square root, CORDIC_STAGES CORDIC, 1 output register.
// Throughput: one transfer per cycle unless out_ready stalls; each cell holds
// one item, advancing when its successor frees; chain length sets the latency.
// Reset: clears all valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module quaternion_to_euler_angles_core #(
    parameter int QUAT_WIDTH    = q2e_pkg::QUAT_WIDTH_DEF,
    parameter int ANGLE_WIDTH   = q2e_pkg::ANGLE_WIDTH_DEF,
    parameter int CORDIC_STAGES = q2e_pkg::CORDIC_STAGES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [q2e_pkg::CFG_IW-1:0]    cfg_index,
    input  logic [q2e_pkg::CFG_DW-1:0]    cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [QUAT_WIDTH-1:0]  quat_w,
    input  logic signed [QUAT_WIDTH-1:0]  quat_x,
    input  logic signed [QUAT_WIDTH-1:0]  quat_y,
    input  logic signed [QUAT_WIDTH-1:0]  quat_z,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [ANGLE_WIDTH-1:0] heading_angle,
    output logic signed [ANGLE_WIDTH-1:0] pitch_angle,
    output logic signed [ANGLE_WIDTH-1:0] bank_angle,
    output logic                          gimbal_lock
);

    localparam int AW  = ANGLE_WIDTH;
    localparam int N   = CORDIC_STAGES;
    localparam int NSQ = q2e_pkg::SQ_STEPS;
    localparam int DW  = q2e_pkg::DW;
    localparam int ZW  = q2e_pkg::ZW;
    localparam int EW  = ZW + 1;
    localparam int SH  = 32 - AW;
    localparam logic signed [EW-1:0] RND    = (SH > 0) ? EW'(64'sd1 <<< (SH - 1)) : '0;
    localparam logic signed [EW-1:0] A_HI   = EW'((64'sd1 <<< (AW - 1)) - 64'sd1);
    localparam logic signed [EW-1:0] A_LO   = -EW'(64'sd1 <<< (AW - 1));
    localparam logic signed [EW-1:0] P_HI   = EW'(64'sd1 <<< (AW - 2));
    localparam logic signed [AW-1:0] PMAX   = AW'(64'sd1 <<< (AW - 2));

    function automatic logic signed [AW-1:0] to_angle(
        input logic signed [ZW-1:0] z,
        input logic signed [EW-1:0] lo,
        input logic signed [EW-1:0] hi
    );
        logic signed [EW-1:0] r;
        r = (EW'(z) + RND) >>> SH;
        if (r > hi)
            r = hi;
        else if (r < lo)
            r = lo;
        return AW'(r);
    endfunction

    logic                         direction_reg;
    logic [q2e_pkg::CFG_DW-1:0]   threshold_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg <= 1'b0;
            threshold_reg <= q2e_pkg::THRESHOLD_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                q2e_pkg::REG_DIRECTION: direction_reg <= cfg_data[0];
                q2e_pkg::REG_THRESHOLD: threshold_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    logic           sq_valid [0:NSQ];
    logic           sq_ready [0:NSQ];
    q2e_pkg::sqrt_t sq_data  [0:NSQ];

    q2e_front #(
        .QW (QUAT_WIDTH),
        .AW (ANGLE_WIDTH)
    ) u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .direction        (direction_reg),
        .gimbal_threshold (threshold_reg),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .quat_w           (quat_w),
        .quat_x           (quat_x),
        .quat_y           (quat_y),
        .quat_z           (quat_z),
        .out_valid        (sq_valid[0]),
        .out_ready        (sq_ready[0]),
        .out_data         (sq_data[0])
    );

    for (genvar j = 0; j < NSQ; j++)
    begin : g_sqrt
        q2e_sqrt_cell #(
            .K (NSQ - 1 - j)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (sq_valid[j]),
            .in_ready  (sq_ready[j]),
            .in_data   (sq_data[j]),
            .out_valid (sq_valid[j+1]),
            .out_ready (sq_ready[j+1]),
            .out_data  (sq_data[j+1])
        );
    end

    logic             cd_valid [0:N];
    logic             cd_ready [0:N];
    q2e_pkg::cordic_t cd_data  [0:N];

    always_comb
    begin
        cd_data[0].head       = sq_data[NSQ].head;
        cd_data[0].bank       = sq_data[NSQ].bank;
        cd_data[0].pitch.x    = DW'(sq_data[NSQ].root);
        cd_data[0].pitch.y    = DW'(sq_data[NSQ].s);
        cd_data[0].pitch.z    = '0;
        cd_data[0].pitch.zero = 1'b0;
        cd_data[0].lock       = sq_data[NSQ].lock;
        cd_data[0].gpitch     = sq_data[NSQ].gpitch;
    end

    assign cd_valid[0]   = sq_valid[NSQ];
    assign sq_ready[NSQ] = cd_ready[0];

    for (genvar i = 0; i < N; i++)
    begin : g_cordic
        q2e_cordic_cell #(
            .I (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (cd_valid[i]),
            .in_ready  (cd_ready[i]),
            .in_data   (cd_data[i]),
            .out_valid (cd_valid[i+1]),
            .out_ready (cd_ready[i+1]),
            .out_data  (cd_data[i+1])
        );
    end

    logic                  out_valid_reg;
    logic signed [AW-1:0]  heading_reg, pitch_reg, bank_reg;
    logic                  lock_reg;
    logic signed [AW-1:0]  heading_next, pitch_next, bank_next;
    logic                  o_rdy;

    assign o_rdy       = !out_valid_reg || out_ready;
    assign cd_ready[N] = o_rdy;

    always_comb
    begin
        heading_next = to_angle(cd_data[N].head.z, A_LO, A_HI);
        if (cd_data[N].lock)
        begin
            pitch_next = AW'(cd_data[N].gpitch);
            bank_next  = '0;
        end
        else
        begin
            pitch_next = to_angle(cd_data[N].pitch.z, -P_HI, P_HI);
            bank_next  = to_angle(cd_data[N].bank.z, A_LO, A_HI);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (o_rdy)
            out_valid_reg <= cd_valid[N];
    end

    always_ff @(posedge clk)
    begin
        if (o_rdy && cd_valid[N])
        begin
            heading_reg <= heading_next;
            pitch_reg   <= pitch_next;
            bank_reg    <= bank_next;
            lock_reg    <= cd_data[N].lock;
        end
    end

    assign out_valid     = out_valid_reg;
    assign heading_angle = heading_reg;
    assign pitch_angle   = pitch_reg;
    assign bank_angle    = bank_reg;
    assign gimbal_lock   = lock_reg;

    `Q2E_ASSERT(a_lock_bank_zero, clk, rst_n, out_valid && gimbal_lock |-> bank_angle == '0)
    `Q2E_ASSERT_NEVER(a_pitch_range, clk, rst_n, out_valid && (pitch_angle > PMAX || pitch_angle < -PMAX))
    `Q2E_ASSERT(a_stall_only_on_output, clk, rst_n, !in_ready |-> out_valid && !out_ready)

endmodule

// ----- src/q2e_front.sv -----
// ----------------------------------------------------------------------------
// q2e_front
// Products, pitch sine, gimbal decision, square root seed and CORDIC lane setup in three stages.
// ----------------------------------------------------------------------------
module q2e_front #(
    parameter int QW = q2e_pkg::QUAT_WIDTH_DEF,
    parameter int AW = q2e_pkg::ANGLE_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          direction,
    input  logic [q2e_pkg::CFG_DW-1:0]    gimbal_threshold,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [QW-1:0]          quat_w,
    input  logic signed [QW-1:0]          quat_x,
    input  logic signed [QW-1:0]          quat_y,
    input  logic signed [QW-1:0]          quat_z,
    output logic                          out_valid,
    input  logic                          out_ready,
    output q2e_pkg::sqrt_t                out_data
);

    localparam int PW    = q2e_pkg::PW;
    localparam int DW    = q2e_pkg::DW;
    localparam int S     = 2 * QW - 32;
    localparam int S_POS = (S >= 0) ? S : 0;
    localparam int S_NEG = (S < 0) ? -S : 0;
    localparam int TW    = 2 * QW + 2 + S_NEG;
    localparam int GW    = DW + 32;
    localparam logic signed [GW-1:0] G_RND = GW'(64'sd536870912);
    localparam logic signed [GW-1:0] G_MAX = GW'(64'sd1 <<< (AW - 2));
    localparam logic signed [31:0]   S_ONE = 32'sd1073741824;
    localparam logic [63:0]          C2_ONE = 64'd1 << 60;

    function automatic logic signed [PW-1:0] to_q30(
        input logic signed [QW:0] a,
        input logic signed [QW:0] b
    );
        logic signed [2*QW+1:0] p;
        logic signed [TW-1:0]   t;
        p = a * b;
        t = TW'(p);
        t = (S >= 0) ? (t >>> S_POS) : (t <<< S_NEG);
        return PW'(t);
    endfunction

    function automatic q2e_pkg::lane_t prep(
        input logic signed [DW-1:0] y,
        input logic signed [DW-1:0] x
    );
        q2e_pkg::lane_t l;
        l.zero = (x == '0) && (y == '0);
        if (x[DW-1])
        begin
            l.z = y[DW-1] ? -q2e_pkg::PI_Z : q2e_pkg::PI_Z;
            l.x = -x;
            l.y = -y;
        end
        else
        begin
            l.z = '0;
            l.x = x;
            l.y = y;
        end
        return l;
    endfunction

    // stage A
    logic a_v_reg;
    logic a_rdy;
    logic signed [PW-1:0] xx_reg, yy_reg, zz_reg, xy_reg, xz_reg, yz_reg;
    logic signed [PW-1:0] wx_reg, wy_reg, wz_reg;
    logic signed [QW:0] wd, xe, ye, ze;

    // stage B
    logic b_v_reg;
    logic b_rdy;
    logic signed [DW-1:0] sp_reg, hy_reg, hx_reg, by_reg, bx_reg;
    logic                 lock_reg;
    logic signed [DW-1:0] sp_next, hy_next, hx_next, by_next, bx_next;
    logic [DW-1:0]        asp;
    logic                 lock_next;

    // stage C
    logic c_v_reg;
    logic c_rdy;
    q2e_pkg::sqrt_t c_reg;
    q2e_pkg::sqrt_t c_next;
    logic signed [31:0] s_c;
    logic signed [63:0] s_sq;
    logic signed [GW-1:0] gv, gr, gc;

    assign c_rdy     = !c_v_reg || out_ready;
    assign b_rdy     = !b_v_reg || c_rdy;
    assign a_rdy     = !a_v_reg || b_rdy;
    assign in_ready  = a_rdy;
    assign out_valid = c_v_reg;
    assign out_data  = c_reg;

    assign xe = (QW+1)'(quat_x);
    assign ye = (QW+1)'(quat_y);
    assign ze = (QW+1)'(quat_z);
    assign wd = direction ? -((QW+1)'(quat_w)) : (QW+1)'(quat_w);

    always_comb
    begin
        sp_next = (DW'(wx_reg) - DW'(yz_reg)) <<< 1;
        asp     = sp_next[DW-1] ? DW'(-sp_next) : DW'(sp_next);
        lock_next = asp > DW'(gimbal_threshold);
        if (lock_next)
        begin
            hy_next = DW'(wy_reg) - DW'(xz_reg);
            hx_next = q2e_pkg::HALF_Q30 - DW'(yy_reg) - DW'(zz_reg);
        end
        else
        begin
            hy_next = DW'(xz_reg) + DW'(wy_reg);
            hx_next = q2e_pkg::HALF_Q30 - DW'(xx_reg) - DW'(yy_reg);
        end
        by_next = DW'(xy_reg) + DW'(wz_reg);
        bx_next = q2e_pkg::HALF_Q30 - DW'(xx_reg) - DW'(zz_reg);
    end

    always_comb
    begin
        if (sp_reg > DW'(S_ONE))
            s_c = S_ONE;
        else if (sp_reg < -DW'(S_ONE))
            s_c = -S_ONE;
        else
            s_c = 32'(sp_reg);
        s_sq = s_c * s_c;
        gv = (GW'(sp_reg) <<< (AW - 2)) + G_RND;
        gr = gv >>> 30;
        if (gr > G_MAX)
            gc = G_MAX;
        else if (gr < -G_MAX)
            gc = -G_MAX;
        else
            gc = gr;
        c_next.rem    = q2e_pkg::RW'(C2_ONE - 64'(s_sq));
        c_next.root   = '0;
        c_next.s      = s_c;
        c_next.head   = prep(hy_reg, hx_reg);
        c_next.bank   = prep(by_reg, bx_reg);
        c_next.lock   = lock_reg;
        c_next.gpitch = q2e_pkg::GPW'(gc);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            c_v_reg <= 1'b0;
        end
        else
        begin
            if (a_rdy)
                a_v_reg <= in_valid;
            if (b_rdy)
                b_v_reg <= a_v_reg;
            if (c_rdy)
                c_v_reg <= b_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_rdy && in_valid)
        begin
            xx_reg <= to_q30(xe, xe);
            yy_reg <= to_q30(ye, ye);
            zz_reg <= to_q30(ze, ze);
            xy_reg <= to_q30(xe, ye);
            xz_reg <= to_q30(xe, ze);
            yz_reg <= to_q30(ye, ze);
            wx_reg <= to_q30(wd, xe);
            wy_reg <= to_q30(wd, ye);
            wz_reg <= to_q30(wd, ze);
        end
        if (b_rdy && a_v_reg)
        begin
            sp_reg   <= sp_next;
            lock_reg <= lock_next;
            hy_reg   <= hy_next;
            hx_reg   <= hx_next;
            by_reg   <= by_next;
            bx_reg   <= bx_next;
        end
        if (c_rdy && b_v_reg)
            c_reg <= c_next;
    end

endmodule

// ----- src/q2e_sqrt_cell.sv -----
// ----------------------------------------------------------------------------
// q2e_sqrt_cell
// One restoring square root step: decide result bit K, pass the rest along.
// ----------------------------------------------------------------------------
module q2e_sqrt_cell #(
    parameter int K = 0
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  q2e_pkg::sqrt_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output q2e_pkg::sqrt_t out_data
);

    localparam int RW  = q2e_pkg::RW;
    localparam int RTW = q2e_pkg::RTW;

    logic           valid_reg;
    q2e_pkg::sqrt_t data_reg;
    q2e_pkg::sqrt_t data_next;
    logic [RW-1:0]  trial;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        data_next = in_data;
        trial = (RW'(in_data.root) << (K + 1)) + (RW'(1) << (2 * K));
        if (in_data.rem >= trial)
        begin
            data_next.rem  = in_data.rem - trial;
            data_next.root = in_data.root | (RTW'(1) << K);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            data_reg <= data_next;
    end

endmodule

// ----- src/q2e_cordic_cell.sv -----
// ----------------------------------------------------------------------------
// q2e_cordic_cell
// One vectoring CORDIC micro-rotation on the heading, pitch and bank lanes.
// ----------------------------------------------------------------------------
module q2e_cordic_cell #(
    parameter int I = 0
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  q2e_pkg::cordic_t in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output q2e_pkg::cordic_t out_data
);

    localparam int DW = q2e_pkg::DW;
    localparam logic signed [q2e_pkg::ZW-1:0] ANG = q2e_pkg::atan_angle(5'(I));

    function automatic q2e_pkg::lane_t rotate(input q2e_pkg::lane_t l);
        q2e_pkg::lane_t r;
        logic signed [DW-1:0] xs;
        logic signed [DW-1:0] ys;
        r  = l;
        xs = l.x >>> I;
        ys = l.y >>> I;
        if (!l.zero)
        begin
            if (!l.y[DW-1])
            begin
                r.x = l.x + ys;
                r.y = l.y - xs;
                r.z = l.z + ANG;
            end
            else
            begin
                r.x = l.x - ys;
                r.y = l.y + xs;
                r.z = l.z - ANG;
            end
        end
        return r;
    endfunction

    logic             valid_reg;
    q2e_pkg::cordic_t data_reg;
    q2e_pkg::cordic_t data_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        data_next       = in_data;
        data_next.head  = rotate(in_data.head);
        data_next.pitch = rotate(in_data.pitch);
        data_next.bank  = rotate(in_data.bank);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            data_reg <= data_next;
    end

endmodule
